// File: hw/rtl/accel_motion_event_detector_assert.svh
// Assertion macros for the motion event detector checker.
// Each macro takes a label, an antecedent and a consequent, sampled on clk
// and disabled while arst_n is low.
`ifndef ACCEL_MOTION_EVENT_DETECTOR_ASSERT_SVH
`define ACCEL_MOTION_EVENT_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define AMED_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("amed assertion failed");

// Next-cycle implication
`define AMED_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("amed assertion failed");

`endif

// File: hw/rtl/amed_pkg.sv
`timescale 1ns / 1ps

package amed_pkg;

	// Input item: one sample or a clear of the daily count
	typedef struct packed {
		logic               cmd;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [31:0]        time_ms;
	} sample_t;

	// Result item
	typedef struct packed {
		logic        step_seen;
		logic [31:0] daily_steps;
		logic [31:0] all_steps;
		logic        double_tap;
		logic        wrist_raised;
	} result_t;

	// Command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_TH   = 3'd0,
		CFG_STEP_MIN  = 3'd1,
		CFG_TAP_TH    = 3'd2,
		CFG_TAP_WIN   = 3'd3,
		CFG_RAISE_X   = 3'd4,
		CFG_RAISE_Z   = 3'd5
	} cfg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic [31:0]        step_threshold_sq;
		logic [15:0]        step_holdoff;
		logic [31:0]        tap_threshold_sq;
		logic [15:0]        tap_window;
		logic signed [15:0] raise_x_min;
		logic signed [15:0] raise_z_limit;
	} cfg_t;

	// Reset values: (1.15 g)^2, 300 ms, (2 g)^2, 400 ms, 0.5 g, 0.3 g
	localparam logic [31:0]        RST_STEP_TH  = 32'd355005891;
	localparam logic [15:0]        RST_STEP_MIN = 16'd300;
	localparam logic [31:0]        RST_TAP_TH   = 32'd1073741824;
	localparam logic [15:0]        RST_TAP_WIN  = 16'd400;
	localparam logic signed [15:0] RST_RAISE_X  = 16'sd8192;
	localparam logic signed [15:0] RST_RAISE_Z  = 16'sd4916;

	// Magnitude stage output toward the detectors
	typedef struct packed {
		logic        cmd;
		logic [31:0] m2;
		logic        raised;
	} mag_t;

endpackage

// File: hw/rtl/amed_cfg_regs.sv
`timescale 1ns / 1ps

module amed_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [amed_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	output amed_pkg::cfg_t                    cfg
);

	// Register file; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.step_threshold_sq <= amed_pkg::RST_STEP_TH;
			cfg.step_holdoff      <= amed_pkg::RST_STEP_MIN;
			cfg.tap_threshold_sq  <= amed_pkg::RST_TAP_TH;
			cfg.tap_window        <= amed_pkg::RST_TAP_WIN;
			cfg.raise_x_min       <= amed_pkg::RST_RAISE_X;
			cfg.raise_z_limit     <= amed_pkg::RST_RAISE_Z;
		end else if (cfg_valid) begin
			case (cfg_index)
				amed_pkg::CFG_STEP_TH:  cfg.step_threshold_sq <= cfg_data;
				amed_pkg::CFG_STEP_MIN: cfg.step_holdoff      <= cfg_data[15:0];
				amed_pkg::CFG_TAP_TH:   cfg.tap_threshold_sq  <= cfg_data;
				amed_pkg::CFG_TAP_WIN:  cfg.tap_window        <= cfg_data[15:0];
				amed_pkg::CFG_RAISE_X:  cfg.raise_x_min       <= $signed(cfg_data[15:0]);
				amed_pkg::CFG_RAISE_Z:  cfg.raise_z_limit     <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/amed_mag.sv
`timescale 1ns / 1ps

module amed_mag #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  amed_pkg::sample_t       sample,
	input  amed_pkg::cfg_t          cfg,
	output logic                    mag_valid,
	input  logic                    mag_ready,
	output amed_pkg::mag_t          mag,
	output logic [TIME_WIDTH-1:0]   now_s3
);

	logic                    v_s1, v_s2, v_s3;
	logic                    rdy_s1, rdy_s2, rdy_s3;

	logic                    cmd_s1;
	logic signed [15:0]      x_s1, y_s1, z_s1;
	logic [TIME_WIDTH-1:0]   now_s1;

	logic                    cmd_s2;
	logic [30:0]             sqx_s2, sqy_s2, sqz_s2;
	logic                    raised_s2;
	logic [TIME_WIDTH-1:0]   now_s2;

	logic                    cmd_s3;
	logic [31:0]             m2_s3;
	logic                    raised_s3;

	logic signed [31:0]      px, py, pz;

	// Stage ready chain: a stage takes data when empty or draining
	assign rdy_s3       = !v_s3 || mag_ready;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= sample_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: input register, time masked to TIME_WIDTH
	always_ff @(posedge clk) begin
		if (sample_valid && rdy_s1) begin
			cmd_s1 <= sample.cmd;
			x_s1   <= sample.accel_x;
			y_s1   <= sample.accel_y;
			z_s1   <= sample.accel_z;
			now_s1 <= TIME_WIDTH'(sample.time_ms);
		end
	end

	// Stage 2: per-axis squares and the wrist raise compare
	assign px = x_s1 * x_s1;
	assign py = y_s1 * y_s1;
	assign pz = z_s1 * z_s1;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			cmd_s2    <= cmd_s1;
			sqx_s2    <= px[30:0];
			sqy_s2    <= py[30:0];
			sqz_s2    <= pz[30:0];
			raised_s2 <= (x_s1 > cfg.raise_x_min) && (z_s1 < cfg.raise_z_limit);
			now_s2    <= now_s1;
		end
	end

	// Stage 3: squared magnitude, at most 3 * 2^30
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			cmd_s3    <= cmd_s2;
			m2_s3     <= 32'(sqx_s2) + 32'(sqy_s2) + 32'(sqz_s2);
			raised_s3 <= raised_s2;
			now_s3    <= now_s2;
		end
	end

	assign mag_valid  = v_s3;
	assign mag.cmd    = cmd_s3;
	assign mag.m2     = m2_s3;
	assign mag.raised = raised_s3;

endmodule

// File: hw/rtl/amed_detect.sv
`timescale 1ns / 1ps

module amed_detect #(
	parameter int TIME_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  amed_pkg::cfg_t          cfg,
	input  logic                    mag_valid,
	output logic                    mag_ready,
	input  amed_pkg::mag_t          mag,
	input  logic [TIME_WIDTH-1:0]   now_s3,
	output logic                    result_valid,
	input  logic                    result_stall,
	output amed_pkg::result_t       result
);

	// Detector state
	logic                    below_q;
	logic [TIME_WIDTH-1:0]   last_step_q;
	logic [COUNT_WIDTH-1:0]  daily_q;
	logic [COUNT_WIDTH-1:0]  total_q;
	logic [TIME_WIDTH-1:0]   last_tap_q;
	logic                    tap_pend_q;
	logic                    res_valid_q;
	amed_pkg::result_t       res_q;

	logic                    is_clear;
	logic                    below;
	logic [TIME_WIDTH-1:0]   dt_step;
	logic [TIME_WIDTH-1:0]   dt_tap;
	logic                    step_hit;
	logic                    spike;
	logic                    dtap_hit;
	logic                    take;
	logic [COUNT_WIDTH-1:0]  daily_nx;
	logic [COUNT_WIDTH-1:0]  total_nx;

	assign mag_ready = !res_valid_q || !result_stall;
	assign take      = mag_valid && mag_ready;

	// Crossing, interval and tap window decisions
	always_comb begin
		is_clear = (mag.cmd == amed_pkg::CMD_CLEAR);
		below    = mag.m2 < cfg.step_threshold_sq;
		dt_step  = now_s3 - last_step_q;
		dt_tap   = now_s3 - last_tap_q;
		step_hit = !is_clear && below_q && !below &&
			(dt_step > TIME_WIDTH'(cfg.step_holdoff));
		spike    = !is_clear && (mag.m2 > cfg.tap_threshold_sq);
		dtap_hit = spike && tap_pend_q && (dt_tap < TIME_WIDTH'(cfg.tap_window));
		if (is_clear) begin
			daily_nx = '0;
		end else if (step_hit) begin
			daily_nx = daily_q + 1'b1;
		end else begin
			daily_nx = daily_q;
		end
		total_nx = step_hit ? total_q + 1'b1 : total_q;
	end

	// State update, once per transferred item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q     <= 1'b1;
			last_step_q <= '0;
			daily_q     <= '0;
			total_q     <= '0;
			last_tap_q  <= '0;
			tap_pend_q  <= 1'b0;
		end else if (take) begin
			daily_q <= daily_nx;
			total_q <= total_nx;
			if (!is_clear) begin
				below_q <= below;
			end
			if (step_hit) begin
				last_step_q <= now_s3;
			end
			// Completing tap clears pending and keeps the first tap time
			if (dtap_hit) begin
				tap_pend_q <= 1'b0;
			end else if (spike) begin
				tap_pend_q <= 1'b1;
				last_tap_q <= now_s3;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (mag_ready) begin
			res_valid_q <= mag_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.step_seen    <= step_hit;
			res_q.daily_steps  <= 32'(daily_nx);
			res_q.all_steps    <= 32'(total_nx);
			res_q.double_tap   <= dtap_hit;
			res_q.wrist_raised <= !is_clear && mag.raised;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: hw/rtl/accel_motion_event_detector.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// sample    sample_valid/_stall       sample_t: cmd, accel_x/y/z, time_ms
// result    result_valid/_stall       result_t: step and tap flags, counts
// cfg       cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; each item passes the
// input register, square stage, magnitude stage and output reg in that order.
// The detector state updates in the last stage as the result is registered.
// arst_n clears stage valid bits, detector state and config to reset values.
// A stalled result holds the output register; upstream stages keep filling
// until they are full, then sample_stall rises. cfg_ready is always high.

module accel_motion_event_detector #(
	parameter int TIME_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  amed_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output amed_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [amed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	amed_pkg::cfg_t          cfg;
	amed_pkg::mag_t          mag;
	logic                    mag_valid;
	logic                    mag_ready;
	logic [TIME_WIDTH-1:0]   now_s3;

	assign cfg_ready = 1'b1;

	amed_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	amed_mag #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_mag (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg          (cfg),
		.mag_valid    (mag_valid),
		.mag_ready    (mag_ready),
		.mag          (mag),
		.now_s3       (now_s3)
	);

	amed_detect #(
		.TIME_WIDTH  (TIME_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_detect (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.mag_valid    (mag_valid),
		.mag_ready    (mag_ready),
		.mag          (mag),
		.now_s3       (now_s3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/amed_checker.sv
`timescale 1ns / 1ps
`include "accel_motion_event_detector_assert.svh"

module amed_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	input  logic                            sample_stall,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  amed_pkg::result_t               result,
	input  logic                            cfg_ready
);

	logic [2:0]  inflight_q;
	logic        seen_q;
	logic [31:0] last_all_q;
	logic        in_xfer;
	logic        out_xfer;

	assign in_xfer  = sample_valid && !sample_stall;
	assign out_xfer = result_valid && !result_stall;

	// Items between input transfer and result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	// Total count of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_all_q <= '0;
		end else if (out_xfer) begin
			seen_q     <= 1'b1;
			last_all_q <= result.all_steps;
		end
	end

	`AMED_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	`AMED_ASSERT_NOW(a_no_phantom, out_xfer, inflight_q != 3'd0)
	`AMED_ASSERT_NOW(a_depth, 1'b1, inflight_q <= 3'd4)
	`AMED_ASSERT_NOW(a_empty_takes, !result_valid, !sample_stall && cfg_ready)
	`AMED_ASSERT_NOW(a_step_total, out_xfer && seen_q, result.step_seen == (result.all_steps != last_all_q))

endmodule

bind accel_motion_event_detector amed_checker u_amed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_ready    (cfg_ready)
);

// File: bench/accel_motion_event_detector_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and config channels of the motion event detector,
// keeps its own copy of the detector state and compares every result transfer.
module accel_motion_event_detector_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  amed_pkg::sample_t              sample,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  amed_pkg::result_t              result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [amed_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output int                             error_count,
	output int                             pending_count
);

	// Shadow configuration and detector state
	amed_pkg::cfg_t    regs;
	logic              below_level;
	logic [31:0]       last_step_ms;
	logic [31:0]       daily_cnt;
	logic [31:0]       total_cnt;
	logic [31:0]       last_tap_ms;
	logic              tap_armed;
	amed_pkg::result_t expected_q[$];
	int                mismatches = 0;

	assign error_count = mismatches;

	// Run one sample (or a daily clear) through the detectors
	function automatic amed_pkg::result_t detect_motion(amed_pkg::sample_t s);
		amed_pkg::result_t r;
		longint            ax, ay, az;
		logic [31:0]       m2;
		logic [31:0]       dt;
		logic              under;
		r = '0;
		if (s.cmd == amed_pkg::CMD_CLEAR) begin
			daily_cnt = '0;
		end else begin
			ax = $signed(s.accel_x);
			ay = $signed(s.accel_y);
			az = $signed(s.accel_z);
			// exact squared magnitude, at most 3 * 2^30
			m2 = 32'(ax * ax + ay * ay + az * az);
			under = m2 < regs.step_threshold_sq;

			// step: rising crossing, interval strictly above the minimum
			if (below_level && !under) begin
				dt = s.time_ms - last_step_ms;
				if (dt > 32'(regs.step_holdoff)) begin
					daily_cnt = daily_cnt + 32'd1;
					total_cnt = total_cnt + 32'd1;
					last_step_ms = s.time_ms;
					r.step_seen = 1'b1;
				end
			end
			below_level = under;

			// tap: second spike inside the window completes a double tap
			if (m2 > regs.tap_threshold_sq) begin
				dt = s.time_ms - last_tap_ms;
				if (dt < 32'(regs.tap_window) && tap_armed) begin
					tap_armed = 1'b0;
					r.double_tap = 1'b1;
				end else begin
					tap_armed = 1'b1;
					last_tap_ms = s.time_ms;
				end
			end

			r.wrist_raised = ($signed(s.accel_x) > $signed(regs.raise_x_min)) &&
				($signed(s.accel_z) < $signed(regs.raise_z_limit));
		end
		r.daily_steps = daily_cnt;
		r.all_steps = total_cnt;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Predict on sample transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		amed_pkg::result_t want;
		if (!arst_n) begin
			regs = '{step_threshold_sq: amed_pkg::RST_STEP_TH,
				step_holdoff: amed_pkg::RST_STEP_MIN,
				tap_threshold_sq: amed_pkg::RST_TAP_TH, tap_window: amed_pkg::RST_TAP_WIN,
				raise_x_min: amed_pkg::RST_RAISE_X, raise_z_limit: amed_pkg::RST_RAISE_Z};
			below_level = 1'b1;
			last_step_ms = '0;
			daily_cnt = '0;
			total_cnt = '0;
			last_tap_ms = '0;
			tap_armed = 1'b0;
			expected_q.delete();
			mismatches = 0;
			pending_count <= 0;
		end else begin
			// config writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					amed_pkg::CFG_STEP_TH:  regs.step_threshold_sq = cfg_data;
					amed_pkg::CFG_STEP_MIN: regs.step_holdoff = cfg_data[15:0];
					amed_pkg::CFG_TAP_TH:   regs.tap_threshold_sq = cfg_data;
					amed_pkg::CFG_TAP_WIN:  regs.tap_window = cfg_data[15:0];
					amed_pkg::CFG_RAISE_X:  regs.raise_x_min = cfg_data[15:0];
					amed_pkg::CFG_RAISE_Z:  regs.raise_z_limit = cfg_data[15:0];
					default: ;
				endcase
			end

			if (sample_valid && !sample_stall)
				expected_q.push_back(detect_motion(sample));

			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no sample outstanding");
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					mismatches += field_bad("step_seen", 32'(want.step_seen),
						32'(result.step_seen));
					mismatches += field_bad("daily_steps", want.daily_steps,
						result.daily_steps);
					mismatches += field_bad("all_steps", want.all_steps, result.all_steps);
					mismatches += field_bad("double_tap", 32'(want.double_tap),
						32'(result.double_tap));
					mismatches += field_bad("wrist_raised", 32'(want.wrist_raised),
						32'(result.wrist_raised));
				end
			end
			pending_count <= expected_q.size();
		end
	end

endmodule

// File: bench/accel_motion_event_detector_tb.sv
`timescale 1ns / 1ps

module accel_motion_event_detector_tb;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SEGMENTS      = 12;
	localparam int SEGMENT_ITEMS = 128;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [31:0] MAX_SQ  = 32'd3221225472;
	localparam logic [15:0] MIN_S16 = 16'h8000;
	localparam logic [15:0] MAX_S16 = 16'h7fff;

	typedef enum int {SET_RESET, SET_LOW, SET_HIGH, SET_MIXED, SET_RANDOM} setting_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           sample_valid = 1'b0;
	logic                           sample_stall;
	amed_pkg::sample_t              sample = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	amed_pkg::result_t              result;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [amed_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data = '0;
	int                             error_count;
	int                             pending_count;
	int                             send_gap_pct = 0;
	int                             stall_pct = 0;
	int                             idle_cycles = 0;
	logic [31:0]                    now_ms = '0;

	always #5 clk = ~clk;

	accel_motion_event_detector DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	accel_motion_event_detector_checker motion_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	// Receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99, 0) < stall_pct);
	end

	// Watchdog: give up after a long run of cycles with no transfer
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("accel_motion_event_detector_tb NOT OK");
			$finish;
		end
	end

	function automatic amed_pkg::sample_t make_sample(logic cmd, int x, int y, int z,
			logic [31:0] t);
		amed_pkg::sample_t s;
		s.cmd = cmd;
		s.accel_x = 16'(x);
		s.accel_y = 16'(y);
		s.accel_z = 16'(z);
		s.time_ms = t;
		return s;
	endfunction

	// Random magnitude in [lo, hi] with random sign, clipped to the 16-bit range
	function automatic int axis_value(int lo, int hi);
		int v;
		v = $urandom_range(hi, lo);
		if ($urandom_range(1, 0) == 1)
			v = -v;
		return (v > 32767) ? 32767 : v;
	endfunction

	// Mostly walking-like motion: quiet, step-level and tap-level samples
	function automatic amed_pkg::sample_t next_random_item();
		amed_pkg::sample_t s;
		int                pick;
		int                level;
		int                jump;
		pick = $urandom_range(99, 0);
		level = $urandom_range(99, 0);
		jump = $urandom_range(99, 0);
		if (jump < 4)
			now_ms = $urandom();
		else if (jump < 6)
			now_ms = 32'hffff_ffff - $urandom_range(600, 0);
		else if (jump < 12)
			now_ms = now_ms + $urandom_range(2000, 0);
		else
			now_ms = now_ms + $urandom_range(260, 0);

		if (pick < 8) begin
			s = make_sample(amed_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
				$urandom());
		end else if (pick < 14) begin
			s = make_sample(amed_pkg::CMD_SAMPLE, $urandom(), $urandom(), $urandom(), now_ms);
		end else if (level < 45) begin
			s = make_sample(amed_pkg::CMD_SAMPLE, axis_value(0, 4000), axis_value(0, 4000),
				axis_value(0, 4000), now_ms);
		end else if (level < 80) begin
			s = make_sample(amed_pkg::CMD_SAMPLE, axis_value(0, 4000), axis_value(0, 4000),
				axis_value(0, 4000), now_ms);
			case ($urandom_range(2, 0))
				0: s.accel_x = 16'(axis_value(14000, 26000));
				1: s.accel_y = 16'(axis_value(14000, 26000));
				default: s.accel_z = 16'(axis_value(14000, 26000));
			endcase
		end else begin
			s = make_sample(amed_pkg::CMD_SAMPLE, axis_value(22000, 32768),
				axis_value(22000, 32768), axis_value(22000, 32768), now_ms);
		end
		return s;
	endfunction

	// One sample transfer; payload held while stalled
	task automatic send_item(amed_pkg::sample_t item);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample <= item;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
	endtask

	// Hold off the sender until every result is back
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Caller lowers cfg_valid after the last write
	task automatic write_reg(logic [amed_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(setting_t kind);
		logic [31:0] step_th;
		logic [31:0] tap_th;
		logic [15:0] step_gap;
		logic [15:0] tap_win;
		logic [15:0] x_min;
		logic [15:0] z_lim;
		case (kind)
			SET_RESET: begin
				step_th = amed_pkg::RST_STEP_TH;
				step_gap = amed_pkg::RST_STEP_MIN;
				tap_th = amed_pkg::RST_TAP_TH;
				tap_win = amed_pkg::RST_TAP_WIN;
				x_min = amed_pkg::RST_RAISE_X;
				z_lim = amed_pkg::RST_RAISE_Z;
			end
			SET_LOW: begin
				step_th = '0;
				step_gap = '0;
				tap_th = '0;
				tap_win = '0;
				x_min = MIN_S16;
				z_lim = MIN_S16;
			end
			SET_HIGH: begin
				step_th = MAX_SQ;
				step_gap = 16'hffff;
				tap_th = MAX_SQ;
				tap_win = 16'hffff;
				x_min = MAX_S16;
				z_lim = MAX_S16;
			end
			SET_MIXED: begin
				step_th = '0;
				step_gap = 16'hffff;
				tap_th = '0;
				tap_win = 16'hffff;
				x_min = MIN_S16;
				z_lim = MAX_S16;
			end
			default: begin
				step_th = $urandom_range(1_000_000_000, 50_000_000);
				tap_th = $urandom_range(MAX_SQ, 300_000_000);
				step_gap = 16'($urandom_range(600, 0));
				tap_win = 16'($urandom_range(800, 0));
				x_min = 16'(int'($urandom_range(24000, 0)) - 12000);
				z_lim = 16'(int'($urandom_range(24000, 0)) - 12000);
			end
		endcase
		// upper bits of the 16-bit registers carry junk that must be dropped
		write_reg(amed_pkg::CFG_STEP_TH, step_th);
		write_reg(amed_pkg::CFG_STEP_MIN, {16'($urandom()), step_gap});
		write_reg(amed_pkg::CFG_TAP_TH, tap_th);
		write_reg(amed_pkg::CFG_TAP_WIN, {16'($urandom()), tap_win});
		write_reg(amed_pkg::CFG_RAISE_X, {16'($urandom()), x_min});
		write_reg(amed_pkg::CFG_RAISE_Z, {16'($urandom()), z_lim});
		// indexes past the register list are ignored by the block
		for (int k = int'(amed_pkg::CFG_RAISE_Z) + 1; k < (1 << amed_pkg::CFG_IDX_W); k++)
			write_reg(k[amed_pkg::CFG_IDX_W-1:0], $urandom());
		cfg_valid <= 1'b0;
	endtask

	initial begin
		send_gap_pct = 13;
		stall_pct = 63;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration
		// clear ignores its payload
		send_item(make_sample(amed_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
			$urandom()));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'd0));
		// crossing too soon after the reset step time
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 20000, 0, 0, 32'd100));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'd200));
		// first counted step, wrist raised
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 20000, 0, 0, 32'd301));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'd400));
		// interval exactly at the minimum is not enough
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 20000, 0, 0, 32'd601));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'd700));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, -20000, 32'd1000));
		// double tap inside the window, then spikes at and past its edge
		send_item(make_sample(amed_pkg::CMD_SAMPLE, -32768, -32768, -32768, 32'd2000));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, -32768, -32768, -32768, 32'd2399));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, -32768, -32768, -32768, 32'd2500));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 32767, 32767, 32767, 32'd2900));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 32767, 32767, 32767, 32'd2901));
		// magnitude equal to the tap level is no spike
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, -32768, 32'd3000));
		send_item(make_sample(amed_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
			$urandom()));
		// wrist raise at its compare edges
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 8192, 0, 0, 32'd3100));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 8193, 0, 4915, 32'd3200));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 8193, 0, 4916, 32'd3300));
		// steps across the timestamp wrap
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'hffff_fe00));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 20000, 0, 0, 32'hffff_ff00));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 0, 0, 0, 32'hffff_ffff));
		send_item(make_sample(amed_pkg::CMD_SAMPLE, 20000, 0, 0, 32'h0000_0050));

		// Random segments, each under its own configuration
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			if (seg == 4) begin
				send_gap_pct = 63;
				stall_pct = 13;
			end
			if (seg == 8) begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			load_setting((seg % 6 >= int'(SET_RANDOM)) ? SET_RANDOM : setting_t'(seg % 6));
			repeat (SEGMENT_ITEMS) send_item(next_random_item());
		end
		drain();

		if (error_count == 0 && pending_count == 0)
			$display("accel_motion_event_detector_tb OK");
		else
			$display("accel_motion_event_detector_tb NOT OK");
		$finish;
	end

endmodule
